FILE: rtl/core/sfc_pkg.sv
package sfc_pkg;

    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;
    localparam int READ_BIT = 7;
    localparam int LEN_W = 7;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_CMD   = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4,
        PH_END   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_START = 2'd1,
        ST_MISMATCH  = 2'd2,
        ST_BAD_END   = 2'd3
    } status_t;

    typedef struct packed {
        logic             frame_end;
        logic [7:0]       cmd_code;
        logic             write_flag;
        logic [LEN_W-1:0] payload_len;
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] payload_index;
        status_t          status;
    } result_t;

endpackage

FILE: rtl/core/sfc_in_if.sv
interface sfc_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);

endinterface

FILE: rtl/core/sfc_out_if.sv
interface sfc_out_if;

    logic                      valid;
    logic                      ready;
    logic                      frame_end;
    logic [7:0]                cmd_code;
    logic                      write_flag;
    logic [sfc_pkg::LEN_W-1:0] payload_len;
    logic [7:0]                payload_byte;
    logic [sfc_pkg::LEN_W-1:0] payload_index;
    logic [1:0]                status;

    modport source (
        output valid, output frame_end, output cmd_code, output write_flag,
        output payload_len, output payload_byte, output payload_index,
        output status, input ready
    );
    modport sink (
        input valid, input frame_end, input cmd_code, input write_flag,
        input payload_len, input payload_byte, input payload_index,
        input status, output ready
    );

endinterface

FILE: rtl/core/sfc_parser.sv
module sfc_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       data,
    input  logic             take,
    output logic             emit,
    output sfc_pkg::result_t result
);

    sfc_pkg::phase_t                phase_reg, phase_next;
    logic [7:0]                     cmd_reg, cmd_next;
    logic                           write_reg, write_next;
    logic [sfc_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [sfc_pkg::LEN_W-1:0]      count_reg, count_next;
    logic [7:0]                     check_reg, check_next;
    logic [sfc_pkg::LEN_W-1:0]      count_inc;

    assign count_inc = count_reg + sfc_pkg::LEN_W'(1);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        write_next = write_reg;
        len_next   = len_reg;
        count_next = count_reg;
        check_next = check_reg;
        unique case (phase_reg)
            sfc_pkg::PH_CMD:
            begin
                cmd_next   = data;
                check_next = data;
                phase_next = sfc_pkg::PH_LEN;
            end
            sfc_pkg::PH_LEN:
            begin
                write_next = ~data[sfc_pkg::READ_BIT];
                len_next   = data[sfc_pkg::LEN_W-1:0];
                check_next = check_reg ^ data;
                count_next = '0;
                if (!data[sfc_pkg::READ_BIT] && data[sfc_pkg::LEN_W-1:0] != '0)
                begin
                    phase_next = sfc_pkg::PH_DATA;
                end
                else
                begin
                    phase_next = sfc_pkg::PH_CHECK;
                end
            end
            sfc_pkg::PH_DATA:
            begin
                check_next = check_reg ^ data;
                count_next = count_inc;
                if (count_inc >= len_reg)
                begin
                    phase_next = sfc_pkg::PH_CHECK;
                end
            end
            sfc_pkg::PH_CHECK:
            begin
                phase_next = (data != check_reg) ? sfc_pkg::PH_HUNT : sfc_pkg::PH_END;
            end
            sfc_pkg::PH_END:
            begin
                phase_next = sfc_pkg::PH_HUNT;
            end
            default:
            begin
                phase_next = (data == sfc_pkg::STX_BYTE) ? sfc_pkg::PH_CMD
                                                         : sfc_pkg::PH_HUNT;
            end
        endcase
    end

    // result for the byte at hand
    always_comb
    begin
        emit                 = 1'b0;
        result.frame_end     = 1'b1;
        result.cmd_code      = cmd_reg;
        result.write_flag    = write_reg;
        result.payload_len   = len_reg;
        result.payload_byte  = '0;
        result.payload_index = '0;
        result.status        = sfc_pkg::ST_OK;
        unique case (phase_reg)
            sfc_pkg::PH_CMD, sfc_pkg::PH_LEN:
            begin
                emit = 1'b0;
            end
            sfc_pkg::PH_DATA:
            begin
                emit                 = 1'b1;
                result.frame_end     = 1'b0;
                result.payload_byte  = data;
                result.payload_index = count_reg;
            end
            sfc_pkg::PH_CHECK:
            begin
                emit          = (data != check_reg);
                result.status = sfc_pkg::ST_MISMATCH;
            end
            sfc_pkg::PH_END:
            begin
                emit          = 1'b1;
                result.status = (data == sfc_pkg::ETX_BYTE) ? sfc_pkg::ST_OK
                                                            : sfc_pkg::ST_BAD_END;
            end
            default:
            begin
                emit               = (data != sfc_pkg::STX_BYTE);
                result.cmd_code    = '0;
                result.write_flag  = 1'b0;
                result.payload_len = '0;
                result.status      = sfc_pkg::ST_BAD_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfc_pkg::PH_HUNT;
            cmd_reg   <= '0;
            write_reg <= 1'b0;
            len_reg   <= '0;
            count_reg <= '0;
            check_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            write_reg <= write_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            check_reg <= check_next;
        end
    end

endmodule

FILE: rtl/core/sfc_out_reg.sv
module sfc_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sfc_pkg::result_t result,
    output logic             can_load,
    sfc_out_if.source        report
);

    logic             valid_reg, valid_next;
    sfc_pkg::result_t data_reg;

    assign can_load = !valid_reg || report.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (report.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign report.valid         = valid_reg;
    assign report.frame_end     = data_reg.frame_end;
    assign report.cmd_code      = data_reg.cmd_code;
    assign report.write_flag    = data_reg.write_flag;
    assign report.payload_len   = data_reg.payload_len;
    assign report.payload_byte  = data_reg.payload_byte;
    assign report.payload_index = data_reg.payload_index;
    assign report.status        = data_reg.status;

endmodule

FILE: rtl/core/serial_frame_checker.sv
// channel  modport  payload
// rx       sink     rx_byte
// report   source   frame_end, cmd_code, write_flag, payload_len,
//                   payload_byte, payload_index, status
//
// one byte per cycle sustained unless report stalls; a byte's result reaches the report register
// after its transfer on rx (input register, then result register)
// the frame state updates as a byte leaves the input register
// rst_n clears the frame state to hunting and empties both registers
// a stalled report holds only bytes that would add a result; others pass
module serial_frame_checker (
    input  logic      clk,
    input  logic      rst_n,
    sfc_in_if.sink    rx,
    sfc_out_if.source report
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             take;
    logic             emit;
    logic             can_load;
    sfc_pkg::result_t result;

    assign take     = in_valid_reg && (!emit || can_load);
    assign rx.ready = !in_valid_reg || take;

    always_comb
    begin
        if (rx.valid && rx.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (take)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    sfc_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (in_byte_reg),
        .take   (take),
        .emit   (emit),
        .result (result)
    );

    sfc_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take && emit),
        .result   (result),
        .can_load (can_load),
        .report   (report)
    );

`ifndef SYNTH
    a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
        report.valid && !report.frame_end |->
            report.status == sfc_pkg::ST_OK && report.write_flag
            && report.payload_index < report.payload_len)
        else $error("payload result with bad status or index");

    a_bad_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        report.valid && report.status == sfc_pkg::ST_BAD_START |->
            report.frame_end && report.cmd_code == 8'h00
            && report.payload_len == '0 && !report.write_flag)
        else $error("bad start report carries frame fields");

    a_no_load_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        take && emit |-> can_load)
        else $error("result loaded over a stalled one");

    a_report_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        report.valid && report.frame_end |->
            report.payload_byte == 8'h00 && report.payload_index == '0)
        else $error("report carries payload fields");
`endif

endmodule
